// ----- sv/gdd_pkg.sv -----
package gdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIST_W  = 22;

   // Highest year accepted as a valid date.
   localparam int MAX_YEAR = 9999;

   // Day number from 0000-01-01; wide enough for the largest 14-bit year.
   localparam int DNUM_W = 23;
   localparam int Q100_W = 8;
   localparam int LCNT_W = 13;
   localparam int OFF_W  = 9;
   localparam int PROD_W = 27;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 43690.
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic              valid;
      logic [DNUM_W-1:0] number;
   } date_info_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [OFF_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [OFF_W-1:0] start;
      unique case (m)
         4'd1:    start = 9'd0;
         4'd2:    start = 9'd31;
         4'd3:    start = 9'd59;
         4'd4:    start = 9'd90;
         4'd5:    start = 9'd120;
         4'd6:    start = 9'd151;
         4'd7:    start = 9'd181;
         4'd8:    start = 9'd212;
         4'd9:    start = 9'd243;
         4'd10:   start = 9'd273;
         4'd11:   start = 9'd304;
         4'd12:   start = 9'd334;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ----- sv/gdd_req_if.sv -----
interface gdd_req_if;
   logic                        valid;
   logic                        ready;
   logic [gdd_pkg::DAY_W-1:0]   first_day;
   logic [gdd_pkg::MONTH_W-1:0] first_month;
   logic [gdd_pkg::YEAR_W-1:0]  first_year;
   logic [gdd_pkg::DAY_W-1:0]   second_day;
   logic [gdd_pkg::MONTH_W-1:0] second_month;
   logic [gdd_pkg::YEAR_W-1:0]  second_year;

   modport source (
      output valid, first_day, first_month, first_year,
             second_day, second_month, second_year,
      input  ready
   );

   modport sink (
      input  valid, first_day, first_month, first_year,
             second_day, second_month, second_year,
      output ready
   );
endinterface

// ----- sv/gdd_rsp_if.sv -----
interface gdd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       first_valid;
   logic                       second_valid;
   logic [gdd_pkg::DIST_W-1:0] day_distance;

   modport source (
      output valid, first_valid, second_valid, day_distance,
      input  ready
   );

   modport sink (
      input  valid, first_valid, second_valid, day_distance,
      output ready
   );
endinterface

// ----- sv/gdd_day_number.sv -----
// Three-stage conversion of one date into a validity flag and a day number.
module gdd_day_number (
   input  logic                        clock,
   input  logic                        en,
   input  logic [gdd_pkg::DAY_W-1:0]   day,
   input  logic [gdd_pkg::MONTH_W-1:0] month,
   input  logic [gdd_pkg::YEAR_W-1:0]  year,
   output gdd_pkg::date_info_type      info
);

   // Stage 1: quotient of the year by 100.
   logic [gdd_pkg::PROD_W-1:0]  s1_prod;
   logic [gdd_pkg::Q100_W-1:0]  s1_q100_ff, s1_q100_in;
   logic [gdd_pkg::DAY_W-1:0]   s1_day_ff;
   logic [gdd_pkg::MONTH_W-1:0] s1_month_ff;
   logic [gdd_pkg::YEAR_W-1:0]  s1_year_ff;

   // Stage 2: leap status, validity, year and month parts of the day number.
   logic                        s2_r100_nz;
   logic                        s2_r400_nz;
   logic                        s2_leap;
   logic [gdd_pkg::DAY_W-1:0]   s2_limit;
   logic [gdd_pkg::LCNT_W-1:0]  s2_quads;
   logic [gdd_pkg::LCNT_W-1:0]  s2_ceil100;
   logic [gdd_pkg::LCNT_W-1:0]  s2_ceil400;
   logic                        s2_valid_ff, s2_valid_in;
   logic [gdd_pkg::DNUM_W-1:0]  s2_y365_ff, s2_y365_in;
   logic [gdd_pkg::LCNT_W-1:0]  s2_lcnt_ff, s2_lcnt_in;
   logic [gdd_pkg::OFF_W-1:0]   s2_off_ff, s2_off_in;

   // Stage 3: final sum.
   logic                        s3_valid_ff;
   logic [gdd_pkg::DNUM_W-1:0]  s3_number_ff, s3_number_in;

   always_comb begin
      s1_prod    = gdd_pkg::PROD_W'(year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
      s1_q100_in = s1_prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::Q100_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_q100_ff  <= s1_q100_in;
         s1_day_ff   <= day;
         s1_month_ff <= month;
         s1_year_ff  <= year;
      end
   end

   always_comb begin
      s2_r100_nz = (15'(s1_q100_ff) * 15'd100) != 15'(s1_year_ff);
      s2_r400_nz = s2_r100_nz || (s1_q100_ff[1:0] != 2'b00);
      s2_leap    = (s1_year_ff[1:0] == 2'b00) && (s2_r100_nz || !s2_r400_nz);

      s2_limit = gdd_pkg::month_len(s1_month_ff);
      if (s1_month_ff == gdd_pkg::MONTH_FEB && s2_leap) begin
         s2_limit = 5'd29;
      end
      s2_valid_in = (32'(s1_year_ff) <= 32'(gdd_pkg::MAX_YEAR))
                 && (s1_month_ff >= gdd_pkg::MONTH_JAN)
                 && (s1_month_ff <= gdd_pkg::MONTH_DEC)
                 && (s1_day_ff != '0)
                 && (s1_day_ff <= s2_limit);

      // Leap years strictly before this year: ceil(y/4) - ceil(y/100) + ceil(y/400).
      s2_quads   = gdd_pkg::LCNT_W'((15'(s1_year_ff) + 15'd3) >> 2);
      s2_ceil100 = gdd_pkg::LCNT_W'(s1_q100_ff) + gdd_pkg::LCNT_W'(s2_r100_nz);
      s2_ceil400 = gdd_pkg::LCNT_W'(s1_q100_ff >> 2) + gdd_pkg::LCNT_W'(s2_r400_nz);
      s2_lcnt_in = s2_quads - s2_ceil100 + s2_ceil400;

      s2_y365_in = gdd_pkg::DNUM_W'(s1_year_ff) * gdd_pkg::DNUM_W'(365);

      s2_off_in = gdd_pkg::month_start(s1_month_ff)
                + gdd_pkg::OFF_W'(s1_day_ff) - 9'd1;
      if (s1_month_ff > gdd_pkg::MONTH_FEB && s2_leap) begin
         s2_off_in = s2_off_in + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_valid_ff <= s2_valid_in;
         s2_y365_ff  <= s2_y365_in;
         s2_lcnt_ff  <= s2_lcnt_in;
         s2_off_ff   <= s2_off_in;
      end
   end

   assign s3_number_in = s2_y365_ff + gdd_pkg::DNUM_W'(s2_lcnt_ff)
                       + gdd_pkg::DNUM_W'(s2_off_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_valid_ff  <= s2_valid_ff;
         s3_number_ff <= s3_number_in;
      end
   end

   assign info.valid  = s3_valid_ff;
   assign info.number = s3_number_ff;

endmodule

// ----- sv/gregorian_date_difference_core.sv -----
// A transaction accepted at a clock edge is loaded into the first of four register
// stages at that edge and moves through the rest in order to the result channel.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while a finished result waits on the result channel.
// Reset clears the stage valid bits and the result valid; payload is not reset.
module gregorian_date_difference_core (
   input  logic      clock,
   input  logic      reset,
   gdd_req_if.sink   req_chan,
   gdd_rsp_if.source rsp_chan
);

   // The pipeline moves whenever the output register is empty or being drained.
   // A stall freezes every stage at once, so no transaction is lost or repeated.
   logic advance;

   // Valid bits that travel alongside the three conversion stages.
   logic [2:0] stage_valid_ff, stage_valid_in;

   gdd_pkg::date_info_type first_info;
   gdd_pkg::date_info_type second_info;

   logic [gdd_pkg::DNUM_W-1:0] raw_diff;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_first_ff, out_first_in;
   logic                       out_second_ff, out_second_in;
   logic [gdd_pkg::DIST_W-1:0] out_dist_ff, out_dist_in;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Each date goes through its own converter; the two run in lock step.
   gdd_day_number u_first (
      .clock (clock),
      .en    (advance),
      .day   (req_chan.first_day),
      .month (req_chan.first_month),
      .year  (req_chan.first_year),
      .info  (first_info)
   );

   gdd_day_number u_second (
      .clock (clock),
      .en    (advance),
      .day   (req_chan.second_day),
      .month (req_chan.second_month),
      .year  (req_chan.second_year),
      .info  (second_info)
   );

   assign stage_valid_in = {stage_valid_ff[1:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else if (advance) begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Final stage: absolute difference of the day numbers. The distance is forced
   // to zero when either date is invalid, and it saturates if it would not fit
   // the result field (only possible with a very large year limit).
   always_comb begin
      if (first_info.number > second_info.number) begin
         raw_diff = first_info.number - second_info.number;
      end else begin
         raw_diff = second_info.number - first_info.number;
      end

      out_valid_in  = stage_valid_ff[2];
      out_first_in  = first_info.valid;
      out_second_in = second_info.valid;

      if (!(first_info.valid && second_info.valid)) begin
         out_dist_in = '0;
      end else if (raw_diff > gdd_pkg::DNUM_W'(gdd_pkg::DIST_MAX)) begin
         out_dist_in = gdd_pkg::DIST_MAX;
      end else begin
         out_dist_in = raw_diff[gdd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
         out_dist_ff   <= out_dist_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.first_valid  = out_first_ff;
   assign rsp_chan.second_valid = out_second_ff;
   assign rsp_chan.day_distance = out_dist_ff;

endmodule

// ----- tb/gdd_date_checker.sv -----
module gdd_date_checker
   import gdd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gdd_req_if   req_mon,
   gdd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count,
   output int   both_valid_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              first_valid;
      logic              second_valid;
      logic [DIST_W-1:0] day_distance;
   } distance_result_type;

   distance_result_type expected_distances[$];

   int fails      = 0;
   int checked    = 0;
   int both_valid = 0;

   function automatic bit is_leap_year(int unsigned year);
      return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
   endfunction

   function automatic int unsigned days_in_month(int unsigned month, bit leap);
      case (month)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic bit calendar_date_ok(int unsigned day, int unsigned month,
                                           int unsigned year);
      if (year > MAX_YEAR) return 1'b0;
      if (month < MONTH_JAN || month > MONTH_DEC) return 1'b0;
      return day >= 1 && day <= days_in_month(month, is_leap_year(year));
   endfunction

   // Days elapsed since 1 January of year 0, which is itself a leap year.
   function automatic int unsigned days_since_epoch(int unsigned day, int unsigned month,
                                                    int unsigned year);
      int unsigned total;
      total = 365 * year;
      if (year > 0)
         total += (year - 1) / 4 - (year - 1) / 100 + (year - 1) / 400 + 1;
      for (int unsigned k = 1; k < month; k++)
         total += days_in_month(k, is_leap_year(year));
      return total + day - 1;
   endfunction

   function automatic distance_result_type predict_distance(
      int unsigned d1, int unsigned m1, int unsigned y1,
      int unsigned d2, int unsigned m2, int unsigned y2);
      distance_result_type res;
      int unsigned         n1, n2, gap;
      res.first_valid  = calendar_date_ok(d1, m1, y1);
      res.second_valid = calendar_date_ok(d2, m2, y2);
      res.day_distance = '0;
      if (res.first_valid && res.second_valid) begin
         n1  = days_since_epoch(d1, m1, y1);
         n2  = days_since_epoch(d2, m2, y2);
         gap = (n1 > n2) ? n1 - n2 : n2 - n1;
         res.day_distance = (gap > DIST_MAX) ? DIST_MAX : gap[DIST_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      distance_result_type got;
      distance_result_type want;
      if (!reset) begin
         // Results are compared before new requests are queued, so a result
         // can never be matched against a pair accepted on the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.first_valid, rsp_mon.second_valid, rsp_mon.day_distance};
            if (expected_distances.size() == 0) begin
               $error("result arrived with no date pair outstanding");
               fails++;
            end else begin
               want = expected_distances.pop_front();
               checked++;
               if (want.first_valid && want.second_valid) both_valid++;
               if (got.first_valid !== want.first_valid) begin
                  $error("first_valid mismatch: expected %0d, actual %0d",
                         want.first_valid, got.first_valid);
                  fails++;
               end
               if (got.second_valid !== want.second_valid) begin
                  $error("second_valid mismatch: expected %0d, actual %0d",
                         want.second_valid, got.second_valid);
                  fails++;
               end
               if (got.day_distance !== want.day_distance) begin
                  $error("day_distance mismatch: expected %0d, actual %0d",
                         want.day_distance, got.day_distance);
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_distances.push_back(predict_distance(
               req_mon.first_day,  req_mon.first_month,  req_mon.first_year,
               req_mon.second_day, req_mon.second_month, req_mon.second_year));
      end
      fail_count       <= fails;
      pending_count    <= expected_distances.size();
      checked_count    <= checked;
      both_valid_count <= both_valid;
   end

endmodule

// ----- tb/tb_gregorian_date_difference_core.sv -----
module tb_gregorian_date_difference_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gdd_pkg::*;

   // Run shape. The random part uses idle bursts on both channels except for
   // a quiet tail at the end, where both sides run at full rate.
   localparam int RANDOM_PAIRS     = 400;
   localparam int QUIET_TAIL       = 60;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Shared controls: idle_on enables random bursts on both sides, and
   // long_hold_req asks the result side for one long hold-off.
   bit idle_on       = 1'b1;
   bit long_hold_req = 1'b0;

   int fail_count;
   int pending_count;
   int checked_count;
   int both_valid_count;
   int quiet_cycles = 0;

   gdd_req_if req_chan ();
   gdd_rsp_if rsp_chan ();

   gregorian_date_difference_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The checker watches both channels, predicts each result and counts
   // every mismatch; this module only produces traffic and the verdict.
   gdd_date_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .both_valid_count (both_valid_count)
   );

   always #5 clock = ~clock;

   // Watchdog: any cycle that moves a transaction on either channel resets the
   // count. The limit is far above the longest legal pause (the long hold-off
   // plus an idle burst), so reaching it means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side. Ready is changed at most once per clock edge. While idling
   // is enabled it drops for random bursts; once, on request, it stays low for
   // a long stretch so that the pipeline fills and back-pressures the input.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one pair of dates and returns at the edge where it is accepted.
   // An optional idle burst comes first, so valid is either held high into the
   // next transaction or dropped, but never both within one time step.
   task automatic offer_dates(input int unsigned d1, input int unsigned m1,
                              input int unsigned y1, input int unsigned d2,
                              input int unsigned m2, input int unsigned y2);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.first_day    <= d1[DAY_W-1:0];
      req_chan.first_month  <= m1[MONTH_W-1:0];
      req_chan.first_year   <= y1[YEAR_W-1:0];
      req_chan.second_day   <= d2[DAY_W-1:0];
      req_chan.second_month <= m2[MONTH_W-1:0];
      req_chan.second_year  <= y2[YEAR_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Most dates are well formed with random content. The rest are raw noise
   // over the full field widths, month ends on century years, which probe the
   // leap rule and the day limit of each month, or any day in the first or last years.
   task automatic pick_date(output int unsigned d, output int unsigned m,
                            output int unsigned y);
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         d = $urandom_range(0, (1 << DAY_W) - 1);
         m = $urandom_range(0, (1 << MONTH_W) - 1);
         y = $urandom_range(0, (1 << YEAR_W) - 1);
      end else if (kind == 1) begin
         d = $urandom_range(28, 31);
         m = $urandom_range(1, 12);
         y = 100 * $urandom_range(0, 99);
      end else if (kind == 2) begin
         d = $urandom_range(1, 31);
         m = $urandom_range(1, 12);
         y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                         : MAX_YEAR - $urandom_range(0, 3);
      end else begin
         d = $urandom_range(1, 28);
         m = $urandom_range(1, 12);
         y = $urandom_range(0, MAX_YEAR);
      end
   endtask

   initial begin
      int unsigned d1, m1, y1, d2, m2, y2;

      // Every request input is known from time zero.
      req_chan.valid        <= 1'b0;
      req_chan.first_day    <= '0;
      req_chan.first_month  <= '0;
      req_chan.first_year   <= '0;
      req_chan.second_day   <= '0;
      req_chan.second_month <= '0;
      req_chan.second_year  <= '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs. Equal dates, and the widest span in both orders.
      offer_dates(1, 1, 0, 1, 1, 0);
      offer_dates(1, 1, 0, 31, 12, MAX_YEAR);
      offer_dates(31, 12, MAX_YEAR, 1, 1, 0);
      // Leap day handling: year 0 and 2000 are leap years, 1900 is not.
      offer_dates(29, 2, 0, 1, 3, 0);
      offer_dates(29, 2, 2000, 1, 3, 2000);
      offer_dates(29, 2, 1900, 1, 3, 1900);
      offer_dates(28, 2, 2023, 29, 2, 2024);
      offer_dates(30, 2, 2000, 1, 1, 2000);
      offer_dates(1, 3, 2100, 28, 2, 2100);
      offer_dates(31, 12, 2400, 1, 1, 2400);
      offer_dates(31, 12, 1999, 1, 1, 2000);
      // Day limits: day zero, the 31st of a short month and of a long one.
      offer_dates(0, 5, 1234, 1, 5, 1234);
      offer_dates(31, 4, 1987, 31, 1, 1987);
      offer_dates(31, 1, 1987, 30, 11, 2012);
      // Month out of range, at zero, just past December and at its maximum.
      offer_dates(15, 0, 500, 15, 13, 500);
      offer_dates(10, 15, 600, 10, 6, 600);
      // Years past the calendar range, up to the widest field value.
      offer_dates(1, 1, MAX_YEAR + 1, 1, 1, MAX_YEAR);
      offer_dates(1, 1, 16383, 1, 1, 2);
      // Both dates invalid: all fields zero, then all fields at their maximum.
      offer_dates(0, 0, 0, 0, 0, 0);
      offer_dates(31, 15, 16383, 31, 15, 16383);

      // From here the result side holds off once for a long stretch while
      // pairs keep coming, which forces the input to stall.
      long_hold_req = 1'b1;

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == RANDOM_PAIRS - QUIET_TAIL) idle_on = 1'b0;
         pick_date(d1, m1, y1);
         if ($urandom_range(0, 2) == 0) begin
            // A second date close to the first: same or following year.
            d2 = $urandom_range(1, 31);
            m2 = $urandom_range(1, 12);
            y2 = (y1 + $urandom_range(0, 1)) % (1 << YEAR_W);
         end else begin
            pick_date(d2, m2, y2);
         end
         offer_dates(d1, m1, y1, d2, m2, y2);
      end
      req_chan.valid <= 1'b0;

      // Wait for every outstanding result, then keep waiting in case an extra
      // result shows up.
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Compared %0d date-pair results, %0d of them with both dates valid,",
               checked_count, both_valid_count);
      $display("covering leap-year edges, invalid fields, random stalls and one long hold-off.");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
